>>> rtl/imuco_pkg.sv
package imuco_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int AtanTableLen = 24;
   localparam int CordicSteps =
      (CORDIC_ITERATIONS > AtanTableLen) ? AtanTableLen : CORDIC_ITERATIONS;
   localparam int IterW = $clog2(CordicSteps);

   localparam int SampleW = 16;
   localparam int VecW = 36;
   localparam int AngW = 27;
   localparam int WeightW = 17;
   localparam int GainW = 32;
   localparam int AngleW = 32;
   localparam int DeltaW = 33;

   localparam logic signed [AngW-1:0] Deg180 = 27'sd11796480;
   localparam logic [29:0] InvGain = 30'd652032874;
   localparam logic signed [AngleW-1:0] AngleLim = 32'sd2147418112;
   localparam logic [WeightW-1:0] WeightOne = 17'd65536;

   typedef enum logic [0:0] {
      CSR_BLEND_WEIGHT   = 1'b0,
      CSR_GYRO_STEP_GAIN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SampleW-1:0] accel_x;
      logic signed [SampleW-1:0] accel_y;
      logic signed [SampleW-1:0] accel_z;
      logic signed [SampleW-1:0] gyro_x;
      logic signed [SampleW-1:0] gyro_y;
      logic signed [SampleW-1:0] gyro_z;
   } sample_type;

   typedef struct packed {
      logic             valid;
      sample_type       sample;
   } queue_out_type;

   typedef struct packed {
      logic [WeightW-1:0] blend_weight;
      logic [GainW-1:0]   gyro_step_gain;
   } cfg_type;

   typedef struct packed {
      logic                   start;
      logic signed [VecW-1:0] x0;
      logic signed [VecW-1:0] y0;
   } cordic_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [VecW-1:0] x;
      logic signed [AngW-1:0] z;
   } cordic_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROLL,
      S_MAG_LO,
      S_MAG_HI,
      S_PITCH,
      S_GYRO,
      S_BLEND_MUL,
      S_BLEND_ADD,
      S_YAW,
      S_OUT
   } back_state_type;

   function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [AngW-1:0] v;
      case (idx)
         5'd0:  v = 27'sd2949120;
         5'd1:  v = 27'sd1740967;
         5'd2:  v = 27'sd919879;
         5'd3:  v = 27'sd466945;
         5'd4:  v = 27'sd234379;
         5'd5:  v = 27'sd117304;
         5'd6:  v = 27'sd58666;
         5'd7:  v = 27'sd29335;
         5'd8:  v = 27'sd14668;
         5'd9:  v = 27'sd7334;
         5'd10: v = 27'sd3667;
         5'd11: v = 27'sd1833;
         5'd12: v = 27'sd917;
         5'd13: v = 27'sd458;
         5'd14: v = 27'sd229;
         5'd15: v = 27'sd115;
         5'd16: v = 27'sd57;
         5'd17: v = 27'sd29;
         5'd18: v = 27'sd14;
         5'd19: v = 27'sd7;
         5'd20: v = 27'sd4;
         5'd21: v = 27'sd2;
         5'd22: v = 27'sd1;
         default: v = 27'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/imu_complementary_orientation.sv
// Complementary orientation filter: each accepted transfer of one raw three-axis
// accelerometer and gyroscope sample produces one result transfer with pitch,
// roll and yaw in centidegrees. Pitch and roll blend the gyro-integrated angle
// with an accelerometer angle from two CORDIC vectoring passes; yaw integrates
// gyro z only. Each item in the back end takes two 16-step vectoring passes
// through the single shared CORDIC unit plus the load, multiply, blend and
// output steps; a result still held by rsp_stall keeps the back end waiting
// in its output state until that result is taken. A two-entry
// input queue accepts samples while the back end works, and the result register
// holds a finished result while the next item is computed. Configuration writes
// are always ready and must only occur while the block is idle.
module imu_complementary_orientation (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [15:0]  req_gyro_x,
   input  logic signed [15:0]  req_gyro_y,
   input  logic signed [15:0]  req_gyro_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_pitch_centideg,
   output logic signed [15:0]  rsp_roll_centideg,
   output logic signed [15:0]  rsp_yaw_centideg,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   import imuco_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   sample_type     req_sample;
   queue_out_type  q_out;
   logic           q_pop;
   cordic_req_type cordic_req;
   cordic_rsp_type cordic_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      req_sample.accel_x = req_accel_x;
      req_sample.accel_y = req_accel_y;
      req_sample.accel_z = req_accel_z;
      req_sample.gyro_x = req_gyro_x;
      req_sample.gyro_y = req_gyro_y;
      req_sample.gyro_z = req_gyro_z;
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BLEND_WEIGHT:   cfg_in.blend_weight = csr_wdata[WeightW-1:0];
            CSR_GYRO_STEP_GAIN: cfg_in.gyro_step_gain = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_weight <= 17'd64225;
         cfg_ff.gyro_step_gain <= 32'd327861;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   imuco_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_pop      (q_pop),
      .q_out      (q_out)
   );

   imuco_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   imuco_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_out              (q_out),
      .q_pop              (q_pop),
      .cordic_req         (cordic_req),
      .cordic_rsp         (cordic_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pitch_centideg (rsp_pitch_centideg),
      .rsp_roll_centideg  (rsp_roll_centideg),
      .rsp_yaw_centideg   (rsp_yaw_centideg)
   );

endmodule

>>> rtl/imuco_front.sv
module imuco_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  imuco_pkg::sample_type  req_sample,
   input  logic                   q_pop,
   output imuco_pkg::queue_out_type q_out
);
   import imuco_pkg::*;

   sample_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.sample = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_sample;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("Queue count out of range.");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0)
      else $error("Queue popped while empty.");
`endif

endmodule

>>> rtl/imuco_cordic.sv
module imuco_cordic (
   input  logic                       clock,
   input  logic                       reset,
   input  imuco_pkg::cordic_req_type  req,
   output imuco_pkg::cordic_rsp_type  rsp
);
   import imuco_pkg::*;

   logic signed [VecW-1:0] x_ff, x_in;
   logic signed [VecW-1:0] y_ff, y_in;
   logic signed [AngW-1:0] z_ff, z_in;
   logic [IterW-1:0]       iter_ff, iter_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic signed [VecW-1:0] dx, dy;
   logic signed [AngW-1:0] ang;

   assign rsp.done = done_ff;
   assign rsp.x = x_ff;
   assign rsp.z = z_ff;

   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      ang = atan_entry(5'(iter_ff));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         iter_in = '0;
         if (req.x0 < 0) begin
            x_in = -req.x0;
            y_in = -req.y0;
            z_in = (req.y0 >= 0) ? Deg180 : -Deg180;
         end else begin
            x_in = req.x0;
            y_in = req.y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end else if (y_ff < 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end
         if (iter_ff == IterW'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            iter_in = iter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("CORDIC done without a running pass.");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("CORDIC started while running.");
`endif

endmodule

>>> rtl/imuco_back.sv
module imuco_back (
   input  logic                        clock,
   input  logic                        reset,
   input  imuco_pkg::cfg_type          cfg,
   input  imuco_pkg::queue_out_type    q_out,
   output logic                        q_pop,
   output imuco_pkg::cordic_req_type   cordic_req,
   input  imuco_pkg::cordic_rsp_type   cordic_rsp,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_pitch_centideg,
   output logic signed [15:0]          rsp_roll_centideg,
   output logic signed [15:0]          rsp_yaw_centideg
);
   import imuco_pkg::*;

   back_state_type state_ff, state_in;
   logic [1:0]     idx_ff, idx_in;
   sample_type     sample_ff, sample_in;
   logic signed [AngW-1:0]   roll_meas_ff, roll_meas_in;
   logic signed [AngW-1:0]   pitch_meas_ff, pitch_meas_in;
   logic signed [VecW-1:0]   xr_ff, xr_in;
   logic [47:0]              mag_prod_ff, mag_prod_in;
   logic signed [DeltaW-1:0] delta_ff [3];
   logic signed [DeltaW-1:0] delta_in [3];
   logic signed [50:0]       blend_prod_ff, blend_prod_in;
   logic signed [AngleW-1:0] pitch_ff, pitch_in;
   logic signed [AngleW-1:0] roll_ff, roll_in;
   logic signed [AngleW-1:0] yaw_ff, yaw_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       out_pitch_ff, out_pitch_in;
   logic signed [15:0]       out_roll_ff, out_roll_in;
   logic signed [15:0]       out_yaw_ff, out_yaw_in;

   logic [WeightW-1:0]       alpha, beta;
   logic [47:0]              hi_prod;
   logic [65:0]              mag_sum;
   logic signed [SampleW-1:0] gsel;
   logic signed [48:0]       gprod;
   logic signed [AngleW-1:0] old_sel;
   logic signed [AngW-1:0]   acc_sel;
   logic signed [33:0]       old_plus;
   logic signed [50:0]       acc_prod;
   logic signed [50:0]       blend_sum;
   logic signed [35:0]       blend_new;
   logic signed [VecW-1:0]   pitch_y0;

   function automatic logic signed [AngleW-1:0] sat_angle(input logic signed [35:0] v);
      logic signed [AngleW-1:0] r;
      if (v > 36'(AngleLim)) begin
         r = AngleLim;
      end else if (v < -36'(AngleLim)) begin
         r = -AngleLim;
      end else begin
         r = AngleW'(v);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] to_centideg(input logic signed [AngleW-1:0] a);
      logic signed [38:0] scaled;
      logic signed [38:0] biased;
      logic signed [22:0] q;
      logic signed [15:0] r;
      scaled = 39'(a) * 39'sd100;
      biased = scaled + ((scaled < 0) ? 39'sd65535 : 39'sd0);
      q = 23'(biased >>> 16);
      if (q > 23'sd32767) begin
         r = 16'sh7fff;
      end else if (q < -23'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(q);
      end
      return r;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pitch_centideg = out_pitch_ff;
   assign rsp_roll_centideg = out_roll_ff;
   assign rsp_yaw_centideg = out_yaw_ff;

   always_comb begin
      alpha = (cfg.blend_weight > WeightOne) ? WeightOne : cfg.blend_weight;
      beta = WeightOne - alpha;
      hi_prod = 48'(xr_ff[35:18]) * 48'(InvGain);
      mag_sum = 66'(mag_prod_ff) + (66'(hi_prod) << 18);
      case (idx_ff)
         2'd0:    gsel = sample_ff.gyro_y;
         2'd1:    gsel = sample_ff.gyro_x;
         default: gsel = sample_ff.gyro_z;
      endcase
      gprod = 49'(gsel) * 49'($signed({1'b0, cfg.gyro_step_gain}));
      old_sel = (idx_ff == 2'd0) ? pitch_ff : roll_ff;
      acc_sel = (idx_ff == 2'd0) ? pitch_meas_ff : roll_meas_ff;
      old_plus = 34'(old_sel) + 34'(delta_ff[idx_ff]);
      acc_prod = 51'($signed({1'b0, beta})) * 51'(acc_sel);
      blend_sum = blend_prod_ff + acc_prod;
      blend_new = 36'(blend_sum >>> 16);
      pitch_y0 = -(VecW'(sample_ff.accel_x) <<< 16);

      state_in = state_ff;
      idx_in = idx_ff;
      sample_in = sample_ff;
      roll_meas_in = roll_meas_ff;
      pitch_meas_in = pitch_meas_ff;
      xr_in = xr_ff;
      mag_prod_in = mag_prod_ff;
      delta_in = delta_ff;
      blend_prod_in = blend_prod_ff;
      pitch_in = pitch_ff;
      roll_in = roll_ff;
      yaw_in = yaw_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_pitch_in = out_pitch_ff;
      out_roll_in = out_roll_ff;
      out_yaw_in = out_yaw_ff;
      q_pop = 1'b0;
      cordic_req.start = 1'b0;
      cordic_req.x0 = VecW'(q_out.sample.accel_z) <<< 16;
      cordic_req.y0 = VecW'(q_out.sample.accel_y) <<< 16;

      case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop = 1'b1;
               sample_in = q_out.sample;
               cordic_req.start = 1'b1;
               state_in = S_ROLL;
            end
         end
         S_ROLL: begin
            if (cordic_rsp.done) begin
               roll_meas_in = cordic_rsp.z;
               xr_in = cordic_rsp.x;
               state_in = S_MAG_LO;
            end
         end
         S_MAG_LO: begin
            mag_prod_in = 48'(xr_ff[17:0]) * 48'(InvGain);
            state_in = S_MAG_HI;
         end
         S_MAG_HI: begin
            cordic_req.start = 1'b1;
            cordic_req.x0 = $signed(mag_sum[65:30]);
            cordic_req.y0 = pitch_y0;
            state_in = S_PITCH;
         end
         S_PITCH: begin
            if (cordic_rsp.done) begin
               pitch_meas_in = cordic_rsp.z;
               idx_in = 2'd0;
               state_in = S_GYRO;
            end
         end
         S_GYRO: begin
            delta_in[idx_ff] = DeltaW'(gprod >>> 16);
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               state_in = S_BLEND_MUL;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_BLEND_MUL: begin
            blend_prod_in = 51'($signed({1'b0, alpha})) * 51'(old_plus);
            state_in = S_BLEND_ADD;
         end
         S_BLEND_ADD: begin
            if (idx_ff == 2'd0) begin
               pitch_in = sat_angle(blend_new);
               idx_in = 2'd1;
               state_in = S_BLEND_MUL;
            end else begin
               roll_in = sat_angle(blend_new);
               state_in = S_YAW;
            end
         end
         S_YAW: begin
            yaw_in = sat_angle(36'(yaw_ff) + 36'(delta_ff[2]));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_pitch_in = to_centideg(pitch_ff);
               out_roll_in = to_centideg(roll_ff);
               out_yaw_in = to_centideg(yaw_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
         pitch_ff <= '0;
         roll_ff <= '0;
         yaw_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         pitch_ff <= pitch_in;
         roll_ff <= roll_in;
         yaw_ff <= yaw_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      roll_meas_ff <= roll_meas_in;
      pitch_meas_ff <= pitch_meas_in;
      xr_ff <= xr_in;
      mag_prod_ff <= mag_prod_in;
      delta_ff <= delta_in;
      blend_prod_ff <= blend_prod_in;
      out_pitch_ff <= out_pitch_in;
      out_roll_ff <= out_roll_in;
      out_yaw_ff <= out_yaw_in;
   end

`ifndef ASSERT_OFF
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cordic_rsp.done |-> (state_ff == S_ROLL || state_ff == S_PITCH))
      else $error("CORDIC result arrived outside a wait state.");
   a_pitch_limit: assert property (@(posedge clock) disable iff (reset)
      pitch_ff <= AngleLim && pitch_ff >= -AngleLim)
      else $error("Pitch angle beyond saturation limit.");
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("Result raised outside the output state.");
`endif

endmodule
